### hdl/frs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg
// Shared beat types, codes and the held-entry layout of the frame rate shaper.
// ----------------------------------------------------------------------------
package frs_pkg;

	// config register indexes
	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_PERIOD = 2'd1;
	localparam logic [1:0] CFG_DEPTH  = 2'd2;
	localparam logic [1:0] CFG_WINDOW = 2'd3;

	// modes
	localparam logic [1:0] MODE_VFR = 2'd0;
	localparam logic [1:0] MODE_CFR = 2'd1;
	localparam logic [1:0] MODE_PFR = 2'd2;

	// opcodes
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// result actions
	localparam logic [1:0] ACT_PASS = 2'd0;
	localparam logic [1:0] ACT_DUP  = 2'd1;
	localparam logic [1:0] ACT_DROP = 2'd2;

	localparam logic [30:0] METRIC_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic        opcode;
		logic [15:0] frame_tag;
		logic [39:0] frame_start;
		logic [39:0] frame_stop;
		logic [30:0] motion_value;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] out_tag;
		logic [39:0] out_start;
		logic [39:0] out_stop;
		logic        dup_capped;
		logic [4:0]  frames_held;
		logic        last;
	} out_beat_t;

	// one held frame
	typedef struct packed {
		logic [39:0] start;
		logic [39:0] stop;
		logic [15:0] tag;
		logic [30:0] metric;
	} entry_t;

endpackage

### hdl/frs_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_entry_mem
// Held-frame memory: one write and one registered read per cycle. Metric
// slots never written read back as the largest metric.
// ----------------------------------------------------------------------------
module frs_entry_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  frs_pkg::entry_t  wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output frs_pkg::entry_t  rdata
);

	frs_pkg::entry_t  mem_q [DEPTH];
	frs_pkg::entry_t  rraw_q;
	logic [DEPTH-1:0] mval_q;
	logic             rval_q;

	// array write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re) begin
			rraw_q <= mem_q[raddr];
			rval_q <= mval_q[raddr];
		end
	end

	// metric written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mval_q <= '0;
		else if (we)
			mval_q[waddr] <= 1'b1;
	end

	// unwritten metric reads as max
	always_comb begin
		rdata = rraw_q;
		if (!rval_q)
			rdata.metric = frs_pkg::METRIC_MAX;
	end

endmodule

### hdl/frame_rate_shaper_cfr_pfr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_shaper_cfr_pfr
// Frame rate shaper: pass-through, constant rate and peak rate modes.
// ----------------------------------------------------------------------------
// One item is worked at a time; the next is taken when the sequencer is back
// in idle, while a finished result may still sit in the output register.
// A decision reads the held-frame memory once per entry it looks at: it
// scans the entries for a drop candidate, then moves entries down when a
// frame leaves the window, then sends its result beats (a constant-rate
// frame gives up to MAX_DUPS+1 beats). The memory has a single read port,
// so a step reads its entries one by one, also in the entry move sweep.
// ----------------------------------------------------------------------------
module frame_rate_shaper_cfr_pfr #(
	parameter int WINDOW_DEPTH  = 16,
	parameter int MAX_DUPS      = 31,
	parameter int FRACTION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  frs_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output frs_pkg::out_beat_t  out_data,
	input  logic                cfg_en,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	localparam int TW  = 40 + FRACTION_BITS;
	localparam int CW  = $clog2(WINDOW_DEPTH + 1);
	localparam int IW  = $clog2(WINDOW_DEPTH);
	localparam int DCW = $clog2(MAX_DUPS + 1);

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_START = 15'b000000000000010,
		S_INS   = 15'b000000000000100,
		S_DEC   = 15'b000000000001000,
		S_CHK1  = 15'b000000000010000,
		S_SC0   = 15'b000000000100000,
		S_SCAN  = 15'b000000001000000,
		S_SEND  = 15'b000000010000000,
		S_CHK2  = 15'b000000100000000,
		S_RT    = 15'b000001000000000,
		S_SHIFT = 15'b000010000000000,
		S_EMIT1 = 15'b000100000000000,
		S_CAP   = 15'b001000000000000,
		S_DUP   = 15'b010000000000000,
		S_M0RD  = 15'b100000000000000
	} state_t;

	// config registers
	logic [1:0]  mode_q;
	logic [31:0] period_q;
	logic [4:0]  depth_q;
	logic [31:0] window_q;

	// control and datapath registers
	state_t             state_q;
	state_t             after_q;
	frs_pkg::in_beat_t  in_q;
	logic [CW-1:0]      cnt_q;
	logic [TW-1:0]      oet_q;
	logic               known_q;
	logic [IW-1:0]      n_q;
	logic [TW-1:0]      prod_q;
	logic [39:0]        start0_q;
	logic [39:0]        prev_stop_q;
	logic [CW-1:0]      ii_q;
	logic [IW-1:0]      mn_q;
	frs_pkg::entry_t    min_q;
	logic [CW-1:0]      wr_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      lim_q;
	logic               pend_q;
	frs_pkg::out_beat_t res_q;
	logic [15:0]        tag_q;
	logic [TW-1:0]      t0_q;
	logic [TW-1:0]      excess_q;
	logic               ge_q;
	logic [TW-1:0]      cap_q;
	logic [TW-1:0]      rem_q;
	logic [DCW-1:0]     dcnt_q;
	logic               dcap_q;
	logic               out_valid_q;
	frs_pkg::out_beat_t out_q;

	// memory port
	logic            mem_we;
	logic [IW-1:0]   mem_waddr;
	frs_pkg::entry_t mem_wdata;
	logic            mem_re;
	logic [IW-1:0]   mem_raddr;
	frs_pkg::entry_t rdata;

	// combinational helpers
	logic [7:0]    depth_eff;
	logic [IW-1:0] ins_idx;
	logic [CW-1:0] mul_b;
	logic [TW-1:0] tgt;
	logic [40:0]   span;
	logic          brk;
	logic [CW-1:0] ii_nxt;
	logic          out_free;
	logic [TW-1:0] cfr_rt;
	logic [TW-1:0] sf_rt;
	logic [TW-1:0] pfr_end;
	logic [TW-1:0] period_w;
	logic [TW-1:0] dup_end;
	logic [TW-1:0] rem_nxt;
	logic [DCW-1:0] dcnt_nxt;
	logic          dup_last;
	logic          cap_last;
	logic          shift_done;

	frs_entry_mem #(
		.DEPTH(WINDOW_DEPTH),
		.AW   (IW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// effective depth and insert slot
	always_comb begin
		if (8'(depth_q) < 8'd2)
			depth_eff = 8'd2;
		else if (8'(depth_q) > 8'(WINDOW_DEPTH))
			depth_eff = 8'(WINDOW_DEPTH);
		else
			depth_eff = 8'(depth_q);
		if (cnt_q >= CW'(WINDOW_DEPTH))
			ins_idx = IW'(WINDOW_DEPTH - 1);
		else
			ins_idx = cnt_q[IW-1:0];
	end

	// time arithmetic
	assign period_w  = TW'(period_q);
	assign mul_b     = (state_q == S_DEC) ? cnt_q - CW'(1) : ii_q - CW'(1);
	assign tgt       = oet_q + prod_q;
	assign span      = {1'b0, rdata.stop} - {1'b0, start0_q};
	assign brk       = $signed(span) > $signed({9'd0, window_q});
	assign ii_nxt    = ii_q + CW'(1);
	assign cfr_rt    = oet_q + period_w;
	assign sf_rt     = {rdata.stop, {FRACTION_BITS{1'b0}}};
	assign pfr_end   = (sf_rt < cfr_rt) ? cfr_rt : sf_rt;
	assign dup_end   = oet_q + period_w;
	assign rem_nxt   = rem_q - period_w;
	assign dcnt_nxt  = dcnt_q + DCW'(1);
	assign dup_last  = !((rem_nxt >= period_w) && (dcnt_nxt < DCW'(MAX_DUPS)));
	assign cap_last  = !(ge_q && (excess_q >= period_w));
	assign shift_done = !pend_q && (rd_q >= lim_q);
	assign out_free  = !out_valid_q || !out_stall;

	// memory requests per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = rdata;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_START: begin
				if (mode_q != frs_pkg::MODE_VFR && in_q.opcode == frs_pkg::OP_FRAME) begin
					mem_re    = 1'b1;
					mem_raddr = ins_idx;
				end else if (mode_q == frs_pkg::MODE_VFR && cnt_q != '0) begin
					mem_re = in_q.opcode == frs_pkg::OP_FLUSH;
				end
			end
			S_INS: begin
				mem_we           = 1'b1;
				mem_waddr        = n_q;
				mem_wdata.start  = in_q.frame_start;
				mem_wdata.stop   = in_q.frame_stop;
				mem_wdata.tag    = in_q.frame_tag;
				mem_wdata.metric = (n_q != '0) ? in_q.motion_value : rdata.metric;
			end
			S_DEC: begin
				mem_re    = 1'b1;
				mem_raddr = IW'(cnt_q - CW'(1));
			end
			S_CHK1: mem_re = 1'b1;
			S_SC0: begin
				mem_re    = cnt_q > CW'(1);
				mem_raddr = IW'(1);
			end
			S_SCAN: begin
				mem_re    = !brk && (ii_nxt < cnt_q);
				mem_raddr = ii_nxt[IW-1:0];
			end
			S_CHK2: mem_re = prev_stop_q >= tgt[TW-1:FRACTION_BITS];
			S_SHIFT: begin
				mem_we    = pend_q;
				mem_waddr = wr_q[IW-1:0];
				mem_re    = rd_q < lim_q;
				mem_raddr = rd_q[IW-1:0];
			end
			default: ;
		endcase
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 2'd1;
			period_q <= 32'd196804608;
			depth_q  <= 5'd2;
			window_q <= 32'd6006;
		end else if (cfg_en) begin
			case (cfg_index)
				frs_pkg::CFG_MODE:   mode_q   <= cfg_data[1:0];
				frs_pkg::CFG_PERIOD: period_q <= cfg_data;
				frs_pkg::CFG_DEPTH:  depth_q  <= cfg_data[4:0];
				frs_pkg::CFG_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_q     <= S_IDLE;
			cnt_q       <= '0;
			oet_q       <= '0;
			known_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_START;
				S_START: begin
					if (mode_q == frs_pkg::MODE_VFR) begin
						if (in_q.opcode == frs_pkg::OP_FRAME) begin
							oet_q   <= {in_q.frame_stop, {FRACTION_BITS{1'b0}}};
							known_q <= 1'b1;
							state_q <= S_EMIT1;
						end else if (cnt_q != '0)
							state_q <= S_M0RD;
						else
							state_q <= S_IDLE;
					end else if (in_q.opcode == frs_pkg::OP_FRAME) begin
						if (!known_q) begin
							oet_q   <= {in_q.frame_start, {FRACTION_BITS{1'b0}}};
							known_q <= 1'b1;
						end
						state_q <= S_INS;
					end else if (cnt_q != '0)
						state_q <= S_DEC;
					else
						state_q <= S_IDLE;
				end
				S_INS: begin
					cnt_q <= CW'(n_q) + CW'(1);
					if (n_q != '0 && (8'(n_q) + 8'd1) >= depth_eff)
						state_q <= S_DEC;
					else
						state_q <= S_IDLE;
				end
				S_DEC: state_q <= S_CHK1;
				S_CHK1: begin
					if (rdata.stop >= tgt[TW-1:FRACTION_BITS])
						state_q <= S_RT;
					else
						state_q <= S_SC0;
				end
				S_SC0: state_q <= (cnt_q > CW'(1)) ? S_SCAN : S_SEND;
				S_SCAN: begin
					if (brk || ii_nxt >= cnt_q)
						state_q <= S_SEND;
				end
				S_SEND: state_q <= S_CHK2;
				S_CHK2: begin
					if (prev_stop_q >= tgt[TW-1:FRACTION_BITS])
						state_q <= S_RT;
					else begin
						cnt_q   <= cnt_q - CW'(1);
						pend_q  <= 1'b0;
						after_q <= S_EMIT1;
						state_q <= S_SHIFT;
					end
				end
				S_RT: begin
					cnt_q  <= cnt_q - CW'(1);
					pend_q <= 1'b0;
					if (mode_q == frs_pkg::MODE_CFR) begin
						oet_q   <= cfr_rt;
						after_q <= S_CAP;
					end else begin
						oet_q   <= pfr_end;
						after_q <= S_EMIT1;
					end
					state_q <= S_SHIFT;
				end
				S_M0RD: begin
					oet_q   <= {rdata.stop, {FRACTION_BITS{1'b0}}};
					known_q <= 1'b1;
					cnt_q   <= cnt_q - CW'(1);
					pend_q  <= 1'b0;
					after_q <= S_EMIT1;
					state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (shift_done)
						state_q <= after_q;
					else
						pend_q <= rd_q < lim_q;
				end
				S_EMIT1: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_CAP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= cap_last ? S_IDLE : S_DUP;
					end
				end
				S_DUP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						oet_q       <= dup_end;
						if (dup_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) in_q <= in_data;
			S_START: begin
				n_q   <= ins_idx;
				res_q <= '{action: frs_pkg::ACT_PASS, out_tag: in_q.frame_tag,
					out_start: in_q.frame_start, out_stop: in_q.frame_stop,
					dup_capped: 1'b0, frames_held: 5'(cnt_q), last: 1'b1};
			end
			S_DEC: prod_q <= period_w * TW'(mul_b);
			S_SEND: prod_q <= period_w * TW'(mul_b);
			S_SC0: begin
				start0_q    <= rdata.start;
				prev_stop_q <= rdata.stop;
				min_q       <= rdata;
				mn_q        <= '0;
				ii_q        <= CW'(1);
			end
			S_SCAN: begin
				if (!brk) begin
					if (rdata.metric < min_q.metric) begin
						min_q <= rdata;
						mn_q  <= ii_q[IW-1:0];
					end
					prev_stop_q <= rdata.stop;
					ii_q        <= ii_nxt;
				end
			end
			S_CHK2: begin
				res_q <= '{action: frs_pkg::ACT_DROP, out_tag: min_q.tag,
					out_start: min_q.start, out_stop: min_q.stop,
					dup_capped: 1'b0, frames_held: 5'(cnt_q - CW'(1)), last: 1'b1};
				wr_q  <= CW'(mn_q);
				rd_q  <= CW'(mn_q) + CW'(1);
				lim_q <= cnt_q;
			end
			S_RT: begin
				tag_q    <= rdata.tag;
				t0_q     <= oet_q;
				excess_q <= sf_rt - cfr_rt;
				ge_q     <= sf_rt >= cfr_rt;
				cap_q    <= period_w * TW'(MAX_DUPS + 1);
				res_q    <= '{action: frs_pkg::ACT_PASS, out_tag: rdata.tag,
					out_start: oet_q[TW-1:FRACTION_BITS],
					out_stop: pfr_end[TW-1:FRACTION_BITS],
					dup_capped: 1'b0, frames_held: 5'(cnt_q - CW'(1)), last: 1'b1};
				wr_q  <= '0;
				rd_q  <= CW'(1);
				lim_q <= cnt_q;
			end
			S_M0RD: begin
				res_q <= '{action: frs_pkg::ACT_PASS, out_tag: rdata.tag,
					out_start: rdata.start, out_stop: rdata.stop,
					dup_capped: 1'b0, frames_held: 5'(cnt_q - CW'(1)), last: 1'b1};
				wr_q  <= '0;
				rd_q  <= CW'(1);
				lim_q <= cnt_q;
			end
			S_SHIFT: begin
				if (!shift_done) begin
					if (pend_q)
						wr_q <= wr_q + CW'(1);
					if (rd_q < lim_q)
						rd_q <= rd_q + CW'(1);
				end
			end
			S_EMIT1: if (out_free) out_q <= res_q;
			S_CAP: begin
				if (out_free) begin
					out_q <= '{action: frs_pkg::ACT_PASS, out_tag: tag_q,
						out_start: t0_q[TW-1:FRACTION_BITS],
						out_stop: oet_q[TW-1:FRACTION_BITS],
						dup_capped: ge_q && (excess_q >= cap_q),
						frames_held: 5'(cnt_q), last: cap_last};
					dcap_q <= ge_q && (excess_q >= cap_q);
					rem_q  <= excess_q;
					dcnt_q <= '0;
				end
			end
			S_DUP: begin
				if (out_free) begin
					out_q <= '{action: frs_pkg::ACT_DUP, out_tag: tag_q,
						out_start: oet_q[TW-1:FRACTION_BITS],
						out_stop: dup_end[TW-1:FRACTION_BITS],
						dup_capped: dcap_q, frames_held: 5'(cnt_q), last: dup_last};
					rem_q  <= rem_nxt;
					dcnt_q <= dcnt_nxt;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(WINDOW_DEPTH))
		else $error("held count above window depth");

	a_mem_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("memory read and write hit one entry");

	a_dup_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUP) |-> (dcnt_q < DCW'(MAX_DUPS)))
		else $error("duplicate count past cap");

	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.action == frs_pkg::ACT_DROP) |-> out_q.last)
		else $error("drop beat without last");

endmodule
